### design/zfl_pkg.sv
// ----------------------------------------------------------------------------
// zfl_pkg
// Types, lens breakpoint ROM and fixed-point constants for the zoom focal
// length interpolator.
// ----------------------------------------------------------------------------
package zfl_pkg;

   localparam int ROM_ROWS    = 16;
   localparam int ROW_W       = 4;
   localparam int STEP_W      = 8;
   localparam int FOCAL_W     = 16;
   localparam int FOV_W       = 7;
   localparam int EQ_W        = 22;
   localparam int MAG_W       = 8;
   localparam int CROP_W      = 16;
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 25;

   localparam logic [CROP_W-1:0] CROP_RESET = 16'd5458;

   // crop * fl / 1000 = ((crop * fl) >> 3) / 125, exact reciprocal for 29-bit values
   localparam int          EQ_PRE_SHIFT = 3;
   localparam int          EQ_SHIFT     = 36;
   localparam logic [29:0] EQ_RECIP     = 30'd549755814;

   // fl * 10 / 5000 = (fl >> 2) / 125, exact for 14-bit values
   localparam int          MAG_PRE_SHIFT = 2;
   localparam int          MAG_SHIFT     = 21;
   localparam logic [14:0] MAG_RECIP     = 15'd16778;

   localparam logic [STEP_W-1:0] STEP_ROM [ROM_ROWS] = '{
      8'd0, 8'd16, 8'd32, 8'd62, 8'd78, 8'd102, 8'd125,
      8'd125, 8'd125, 8'd125, 8'd125, 8'd125, 8'd125, 8'd125, 8'd125, 8'd125
   };

   localparam logic [FOCAL_W-1:0] FOCAL_ROM [ROM_ROWS] = '{
      16'd5000, 16'd6800, 16'd9100, 16'd16200, 16'd22300, 16'd35900, 16'd60000,
      16'd60000, 16'd60000, 16'd60000, 16'd60000, 16'd60000, 16'd60000,
      16'd60000, 16'd60000, 16'd60000
   };

   localparam logic [FOV_W-1:0] FOV_ROM [ROM_ROWS] = '{
      7'd63, 7'd49, 7'd37, 7'd22, 7'd16, 7'd10, 7'd6,
      7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd6, 7'd6
   };

   // ceil(2^RECIP_SHIFT / span) of the segment that starts at each row;
   // segments of zero span are never interpolated
   localparam logic [RECIP_W-1:0] RECIP_ROM [ROM_ROWS] = '{
      22'd2097152, 22'd2097152, 22'd1118482, 22'd2097152, 22'd1398102, 22'd1458889,
      22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
   };

   typedef struct packed {
      logic [STEP_W-1:0]  offset;
      logic [FOCAL_W-1:0] base_focal;
      logic [FOV_W-1:0]   base_fov;
      logic [FOCAL_W-1:0] rise_focal;
      logic [FOV_W-1:0]   drop_fov;
      logic [RECIP_W-1:0] recip;
   } seg_item_type;

   typedef struct packed {
      logic [FOCAL_W-1:0] focal_length;
      logic [FOV_W-1:0]   field_of_view;
      logic [EQ_W-1:0]    equivalent_length;
      logic [MAG_W-1:0]   magnification_x10;
   } rsp_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### design/zfl_queue.sv
// ----------------------------------------------------------------------------
// zfl_queue
// Small register-based FIFO; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module zfl_queue
   import zfl_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output q_status_type     status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             wr_en, rd_en;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign wr_en        = push && !status.full;
   assign rd_en        = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(wr_en);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rd_en);
      cnt_in    = cnt_ff + CNT_W'(wr_en) - CNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // callers must never push into a full queue or pop an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue pop while empty");

endmodule

### design/zfl_front.sv
// ----------------------------------------------------------------------------
// zfl_front
// Finds the table segment of a zoom step and registers the segment operands.
// ----------------------------------------------------------------------------
module zfl_front
   import zfl_pkg::*;
#(
   parameter int TABLE_POINTS = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [STEP_W-1:0] zoom_position,
   input  q_status_type      mid_status,
   output logic              busy,
   output logic              mid_push,
   output seg_item_type      seg_item
);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_POINTS - 1);

   logic         valid_ff, valid_in;
   seg_item_type item_ff, item_in;
   logic [ROW_W-1:0] seg_sel, seg_next;
   logic             clamp;

   // lowest row of the segment holding the step; rows are ascending
   always_comb begin
      seg_sel = '0;
      for (int k = 1; k <= TABLE_POINTS - 2; k++) begin
         if (STEP_ROM[k] <= zoom_position) begin
            seg_sel = ROW_W'(k);
         end
      end
   end

   assign seg_next = seg_sel + ROW_W'(1);
   assign clamp    = (zoom_position >= STEP_ROM[LAST_ROW]);

   always_comb begin
      if (clamp) begin
         item_in.offset     = '0;
         item_in.base_focal = FOCAL_ROM[LAST_ROW];
         item_in.base_fov   = FOV_ROM[LAST_ROW];
         item_in.rise_focal = '0;
         item_in.drop_fov   = '0;
         item_in.recip      = '0;
      end else begin
         item_in.offset     = zoom_position - STEP_ROM[seg_sel];
         item_in.base_focal = FOCAL_ROM[seg_sel];
         item_in.base_fov   = FOV_ROM[seg_sel];
         item_in.rise_focal = FOCAL_ROM[seg_next] - FOCAL_ROM[seg_sel];
         item_in.drop_fov   = FOV_ROM[seg_sel] - FOV_ROM[seg_next];
         item_in.recip      = RECIP_ROM[seg_sel];
      end
   end

   // the stage holds its beat while the middle queue is full
   assign busy     = valid_ff && mid_status.full;
   assign mid_push = valid_ff && !mid_status.full;
   assign seg_item = item_ff;
   assign valid_in = accept || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### design/zfl_back.sv
// ----------------------------------------------------------------------------
// zfl_back
// Three-stage arithmetic pipeline: interpolation products, reciprocal
// divides, equivalent length and magnification, with result-queue credit.
// ----------------------------------------------------------------------------
module zfl_back
   import zfl_pkg::*;
#(
   parameter int RSP_DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  seg_item_type      seg_item,
   input  q_status_type      mid_status,
   input  q_status_type      rsp_status,
   input  logic [CROP_W-1:0] crop_factor,
   input  logic              rsp_beat,
   output logic              mid_pop,
   output logic              rsp_push,
   output rsp_item_type      rsp_item
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int XF_W  = STEP_W + FOCAL_W;
   localparam int XV_W  = STEP_W + FOV_W;
   localparam int P_W   = CROP_W + FOCAL_W;
   localparam int Y_W   = P_W - EQ_PRE_SHIFT;

   // beats in the pipeline plus beats in the result queue
   logic [CNT_W-1:0] credit_ff, credit_in;

   logic               s1_valid_ff;
   logic [XF_W-1:0]    s1_xf_ff;
   logic [XV_W-1:0]    s1_xv_ff;
   logic [FOCAL_W-1:0] s1_focal_ff;
   logic [FOV_W-1:0]   s1_fov_ff;
   logic [RECIP_W-1:0] s1_recip_ff;

   logic               s2_valid_ff;
   logic [FOCAL_W-1:0] s2_focal_ff, s2_focal_in;
   logic [FOV_W-1:0]   s2_fov_ff, s2_fov_in;

   logic               s3_valid_ff;
   logic [P_W-1:0]     s3_prod_ff, s3_prod_in;
   logic [MAG_W-1:0]   s3_mag_ff, s3_mag_in;
   logic [FOCAL_W-1:0] s3_focal_ff;
   logic [FOV_W-1:0]   s3_fov_ff;

   logic [XF_W+RECIP_W-1:0]          prod_f;
   logic [XV_W+RECIP_W-1:0]          prod_v;
   logic [FOCAL_W-MAG_PRE_SHIFT+14:0] prod_mag;
   logic [Y_W+29:0]                  prod_eq;

   assign mid_pop   = !mid_status.empty && ((credit_ff < CNT_W'(RSP_DEPTH)) || rsp_beat);
   assign credit_in = credit_ff + CNT_W'(mid_pop) - CNT_W'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         credit_ff   <= credit_in;
         s1_valid_ff <= mid_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 2: quotient by segment span through its reciprocal
   always_comb begin
      prod_f      = s1_xf_ff * s1_recip_ff;
      prod_v      = s1_xv_ff * s1_recip_ff;
      s2_focal_in = s1_focal_ff + prod_f[RECIP_SHIFT +: FOCAL_W];
      s2_fov_in   = s1_fov_ff - prod_v[RECIP_SHIFT +: FOV_W];
   end

   // stage 3
   always_comb begin
      s3_prod_in = crop_factor * s2_focal_ff;
      prod_mag   = s2_focal_ff[FOCAL_W-1:MAG_PRE_SHIFT] * MAG_RECIP;
      s3_mag_in  = prod_mag[MAG_SHIFT +: MAG_W];
   end

   assign prod_eq = s3_prod_ff[P_W-1:EQ_PRE_SHIFT] * EQ_RECIP;

   always_ff @(posedge clock) begin
      s1_xf_ff    <= seg_item.offset * seg_item.rise_focal;
      s1_xv_ff    <= seg_item.offset * seg_item.drop_fov;
      s1_focal_ff <= seg_item.base_focal;
      s1_fov_ff   <= seg_item.base_fov;
      s1_recip_ff <= seg_item.recip;
      s2_focal_ff <= s2_focal_in;
      s2_fov_ff   <= s2_fov_in;
      s3_prod_ff  <= s3_prod_in;
      s3_mag_ff   <= s3_mag_in;
      s3_focal_ff <= s2_focal_ff;
      s3_fov_ff   <= s2_fov_ff;
   end

   assign rsp_push                   = s3_valid_ff;
   assign rsp_item.focal_length      = s3_focal_ff;
   assign rsp_item.field_of_view     = s3_fov_ff;
   assign rsp_item.equivalent_length = prod_eq[EQ_SHIFT +: EQ_W];
   assign rsp_item.magnification_x10 = s3_mag_ff;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(RSP_DEPTH))
      else $error("result credit above queue depth");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_status.full || rsp_beat))
      else $error("result beat with no room in result queue");

endmodule

### design/zoom_focal_length_interpolator.sv
// ----------------------------------------------------------------------------
// zoom_focal_length_interpolator
// Lens zoom step to focal length, field of view, 35 mm equivalent length and
// magnification, by interpolation over a breakpoint ROM.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: a beat is taken when push is high and full low.
//   Result side is a queue: the oldest result sits on rsp_* while empty is
//   low and is taken when pop is high.
//   csr_crop_factor is written when csr_valid is high; csr_ready is always
//   high. Write it only while no request is in flight.
// Throughput: one beat per cycle, sustained, as long as results are popped.
// Path: a request beat passes the front register, the middle queue,
//   three arithmetic stages (span multiply, reciprocal divide, crop
//   multiply), then the result queue before its result is visible.
// Stall: when pop stays low the back end stops drawing beats once
//   RSP_DEPTH results are held or in flight; the middle queue and the front
//   register then fill and full goes high. Nothing is dropped.
// Reset: queues empty, crop factor 5458.
// ----------------------------------------------------------------------------
module zoom_focal_length_interpolator
   import zfl_pkg::*;
#(
   parameter int TABLE_POINTS = 7,
   parameter int MID_DEPTH    = 2,
   parameter int RSP_DEPTH    = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [STEP_W-1:0]  req_zoom_position,
   output logic               empty,
   input  logic               pop,
   output logic [FOCAL_W-1:0] rsp_focal_length,
   output logic [FOV_W-1:0]   rsp_field_of_view,
   output logic [EQ_W-1:0]    rsp_equivalent_length,
   output logic [MAG_W-1:0]   rsp_magnification_x10,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CROP_W-1:0]  csr_crop_factor
);

   localparam int SEG_W = $bits(seg_item_type);
   localparam int RSP_W = $bits(rsp_item_type);

   logic [CROP_W-1:0] crop_ff, crop_in;

   logic         accept;
   logic         mid_push, mid_pop, rsp_push, rsp_beat;
   seg_item_type front_item, mid_item;
   rsp_item_type back_item, out_item;
   q_status_type mid_status, rsp_status;
   logic [SEG_W-1:0] mid_data;
   logic [RSP_W-1:0] out_data;

   assign csr_ready = 1'b1;
   assign crop_in   = (csr_valid && csr_ready) ? csr_crop_factor : crop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_ff <= CROP_RESET;
      end else begin
         crop_ff <= crop_in;
      end
   end

   assign accept = push && !full;

   zfl_front #(
      .TABLE_POINTS(TABLE_POINTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .zoom_position(req_zoom_position),
      .mid_status   (mid_status),
      .busy         (full),
      .mid_push     (mid_push),
      .seg_item     (front_item)
   );

   zfl_queue #(
      .WIDTH(SEG_W),
      .DEPTH(MID_DEPTH)
   ) u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (mid_push),
      .push_data(front_item),
      .pop      (mid_pop),
      .pop_data (mid_data),
      .status   (mid_status)
   );

   assign mid_item = seg_item_type'(mid_data);

   zfl_back #(
      .RSP_DEPTH(RSP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .seg_item   (mid_item),
      .mid_status (mid_status),
      .rsp_status (rsp_status),
      .crop_factor(crop_ff),
      .rsp_beat   (rsp_beat),
      .mid_pop    (mid_pop),
      .rsp_push   (rsp_push),
      .rsp_item   (back_item)
   );

   assign rsp_beat = pop && !empty;

   zfl_queue #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(back_item),
      .pop      (rsp_beat),
      .pop_data (out_data),
      .status   (rsp_status)
   );

   assign out_item              = rsp_item_type'(out_data);
   assign empty                 = rsp_status.empty;
   assign rsp_focal_length      = out_item.focal_length;
   assign rsp_field_of_view     = out_item.field_of_view;
   assign rsp_equivalent_length = out_item.equivalent_length;
   assign rsp_magnification_x10 = out_item.magnification_x10;

endmodule

### tb/zoom_focal_length_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoom_focal_length_interpolator_test
// Self-checking bench: zoom positions go in through the request queue port,
// every result beat is compared with a local lens-table interpolator or a typed-in expectation.
// Directed rows cover breakpoints, their neighbors and the clamp region;
// random phases then run at several crop factors with random gaps on both
// sides, one long result back-pressure and idle drains between phases.
// ----------------------------------------------------------------------------
module zoom_focal_length_interpolator_test
   import zfl_pkg::*;
();

   localparam int                LENS_POINTS   = 7;
   localparam logic [15:0]       CROP_POWER_ON = 16'd5458;
   localparam int                PHASE_ITEMS   = 264;
   localparam int                HOLD_AT_BEAT  = 150;
   localparam int                HOLD_CYCLES   = 200;
   localparam int                DRAIN_CYCLES  = 10;
   localparam int                STALL_LIMIT   = 4000;

   // values at both ends of the table, reset crop factor
   localparam rsp_item_type FAR_END  = '{16'd60000, 7'd6, 22'd327480, 8'd120};
   localparam rsp_item_type WIDE_END = '{16'd5000, 7'd63, 22'd27290, 8'd10};
   localparam rsp_item_type NO_PIN   = '0;

   typedef struct {
      logic [7:0]   zoom;
      bit           pinned;
      rsp_item_type rsp;
   } dir_row_type;

   int lens_step  [LENS_POINTS] = '{0, 16, 32, 62, 78, 102, 125};
   int lens_focal [LENS_POINTS] = '{5000, 6800, 9100, 16200, 22300, 35900, 60000};
   int lens_fov   [LENS_POINTS] = '{63, 49, 37, 22, 16, 10, 6};

   dir_row_type dir_rows [20] = '{
      '{8'd0,   1'b1, WIDE_END},
      '{8'd125, 1'b1, FAR_END},
      '{8'd255, 1'b1, FAR_END},
      '{8'd200, 1'b1, FAR_END},
      '{8'd128, 1'b1, FAR_END},
      '{8'd1,   1'b0, NO_PIN},
      '{8'd15,  1'b0, NO_PIN},
      '{8'd16,  1'b0, NO_PIN},
      '{8'd17,  1'b0, NO_PIN},
      '{8'd32,  1'b0, NO_PIN},
      '{8'd47,  1'b0, NO_PIN},
      '{8'd62,  1'b0, NO_PIN},
      '{8'd63,  1'b0, NO_PIN},
      '{8'd78,  1'b0, NO_PIN},
      '{8'd90,  1'b0, NO_PIN},
      '{8'd102, 1'b0, NO_PIN},
      '{8'd103, 1'b0, NO_PIN},
      '{8'd124, 1'b0, NO_PIN},
      '{8'd126, 1'b0, NO_PIN},
      '{8'd127, 1'b0, NO_PIN}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   logic [STEP_W-1:0]   req_zoom_position = '0;
   logic                empty;
   logic                pop = 1'b0;
   logic [FOCAL_W-1:0]  rsp_focal_length;
   logic [FOV_W-1:0]    rsp_field_of_view;
   logic [EQ_W-1:0]     rsp_equivalent_length;
   logic [MAG_W-1:0]    rsp_magnification_x10;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CROP_W-1:0]   csr_crop_factor = '0;

   // typed-in expectation that travels with the request beat
   logic                pin_valid = 1'b0;
   rsp_item_type        pinned_rsp = '0;

   rsp_item_type        lens_due_q [$];
   logic [15:0]         crop_now = CROP_POWER_ON;
   int                  mismatches = 0;
   int                  stall_count = 0;
   bit                  send_burst = 1'b0;

   zoom_focal_length_interpolator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_zoom_position     (req_zoom_position),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_focal_length      (rsp_focal_length),
      .rsp_field_of_view     (rsp_field_of_view),
      .rsp_equivalent_length (rsp_equivalent_length),
      .rsp_magnification_x10 (rsp_magnification_x10),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_crop_factor       (csr_crop_factor)
   );

   always #2 clock = ~clock;

   function automatic rsp_item_type lens_figures(logic [7:0] zp, logic [15:0] crop);
      rsp_item_type r;
      int           fl;
      int           fov;
      int           span;
      int           off;
      longint       eq;
      fl  = lens_focal[LENS_POINTS-1];
      fov = lens_fov[LENS_POINTS-1];
      for (int i = 1; i < LENS_POINTS; i++) begin
         if (int'(zp) <= lens_step[i]) begin
            span = lens_step[i] - lens_step[i-1];
            off  = int'(zp) - lens_step[i-1];
            if (span != 0) begin
               fl  = lens_focal[i-1] + off * (lens_focal[i] - lens_focal[i-1]) / span;
               fov = lens_fov[i-1] - off * (lens_fov[i-1] - lens_fov[i]) / span;
            end else begin
               fl  = lens_focal[i-1];
               fov = lens_fov[i-1];
            end
            break;
         end
      end
      eq = longint'(crop) * longint'(fl) / 1000;
      r.focal_length      = fl[FOCAL_W-1:0];
      r.field_of_view     = fov[FOV_W-1:0];
      r.equivalent_length = eq[EQ_W-1:0];
      r.magnification_x10 = 8'((fl * 10) / 5000);
      return r;
   endfunction

   function automatic logic [7:0] random_zoom();
      int pick;
      int z;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         z = $urandom_range(0, 130);
      end else if (pick <= 7) begin
         z = $urandom_range(0, 255);
      end else begin
         // hug a breakpoint
         z = lens_step[$urandom_range(0, LENS_POINTS-1)] + $urandom_range(0, 2) - 1;
         if (z < 0) z = 0;
      end
      return z[7:0];
   endfunction

   task automatic report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // scoreboard: result check, request capture, config tracking, watchdog
   always @(posedge clock) begin
      rsp_item_type want;
      bit           moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            crop_now = csr_crop_factor;
            moved = 1'b1;
         end
         if (pop && !empty) begin
            moved = 1'b1;
            if (lens_due_q.size() == 0) begin
               $display("%0t: result beat with nothing expected, focal %0d", $time,
                        rsp_focal_length);
               mismatches++;
            end else begin
               want = lens_due_q.pop_front();
               if (rsp_focal_length !== want.focal_length)
                  report("focal_length", want.focal_length, rsp_focal_length);
               if (rsp_field_of_view !== want.field_of_view)
                  report("field_of_view", want.field_of_view, rsp_field_of_view);
               if (rsp_equivalent_length !== want.equivalent_length)
                  report("equivalent_length", want.equivalent_length,
                         rsp_equivalent_length);
               if (rsp_magnification_x10 !== want.magnification_x10)
                  report("magnification_x10", want.magnification_x10,
                         rsp_magnification_x10);
            end
         end
         if (push && !full) begin
            moved = 1'b1;
            lens_due_q.push_back(pin_valid ? pinned_rsp
                                           : lens_figures(req_zoom_position, crop_now));
         end
         stall_count = moved ? 0 : stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     lens_due_q.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic offer_position(logic [7:0] zp, bit pin, rsp_item_type pinned);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push              <= 1'b1;
      req_zoom_position <= zp;
      pin_valid         <= pin;
      pinned_rsp        <= pinned;
      do @(posedge clock); while (full);
   endtask

   task automatic write_crop(logic [15:0] value);
      push <= 1'b0;
      while (lens_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_crop_factor <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // result side: random pops, one long hold-off while requests keep coming
   initial begin
      int  gap;
      int  taken;
      bit  held;
      bit  pop_burst;
      taken     = 0;
      held      = 1'b0;
      pop_burst = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0)
            pop_burst = ($urandom_range(0, 3) == 0);
         if (taken == HOLD_AT_BEAT && !held) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pop_burst ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         taken++;
      end
   end

   initial begin
      logic [15:0] crop_plan [5];
      crop_plan[0] = 16'd0;
      crop_plan[1] = 16'hFFFF;
      crop_plan[2] = 16'($urandom_range(0, 65535));
      crop_plan[3] = 16'd1000;
      crop_plan[4] = 16'($urandom_range(0, 65535));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // power-on crop factor, directed rows
      foreach (dir_rows[i])
         offer_position(dir_rows[i].zoom, dir_rows[i].pinned, dir_rows[i].rsp);

      for (int ph = 0; ph < 5; ph++) begin
         // first random phase keeps going at the power-on crop factor
         if (ph > 0)
            write_crop(crop_plan[ph - 1]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0)
               send_burst = ($urandom_range(0, 3) == 0);
            offer_position(random_zoom(), 1'b0, NO_PIN);
         end
      end
      write_crop(crop_plan[4]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 40 == 0)
            send_burst = ($urandom_range(0, 3) == 0);
         offer_position(random_zoom(), 1'b0, NO_PIN);
      end

      push <= 1'b0;
      while (lens_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
